>>> hw/rtl/isce_pkg.sv
// Shared types, constants and helpers for the interval set core.
// No dependencies.
package isce_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int POINT_W       = 16;
    localparam int COUNT_W       = 7;
    localparam int COUNT_MAX     = 127;
    localparam int ENTRY_W       = 2 * POINT_W;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                  opcode;
        logic [POINT_W-1:0]   range_start;
        logic [POINT_W-1:0]   range_end;
    } req_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0]   count;
        logic                 table_full;
    } rsp_t;

    typedef struct packed
    {
        logic [POINT_W-1:0]   first;
        logic [POINT_W-1:0]   last;
    } entry_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_RESP
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        if (CNT_W > COUNT_W && v > CNT_W'(COUNT_MAX))
        begin
            r = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            r = COUNT_W'(v);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/isce_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module isce_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/isce_engine.sv
// Scan sequencer: valid bits, live count, overlap eviction and slot allocation.
// Depends on isce_pkg; drives the entry RAM ports.
module isce_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  isce_pkg::req_t            req,
    output logic                      res_valid,
    input  logic                      res_ready,
    output isce_pkg::rsp_t            res,
    output logic                      ram_re,
    output logic [isce_pkg::IDX_W-1:0] ram_raddr,
    input  isce_pkg::entry_t          ram_rdata,
    output logic                      ram_we,
    output logic [isce_pkg::IDX_W-1:0] ram_waddr,
    output isce_pkg::entry_t          ram_wdata
);

    localparam int N  = isce_pkg::TABLE_ENTRIES;
    localparam int IW = isce_pkg::IDX_W;
    localparam int CW = isce_pkg::CNT_W;
    localparam int PW = isce_pkg::POINT_W;

    isce_pkg::state_t state_reg, state_next;
    logic [IW:0]      cnt_reg, cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IW-1:0]    chk_idx_reg, chk_idx_next;
    logic             ent_vld_reg, ent_vld_next;
    logic [PW-1:0]    lo_reg, lo_next;
    logic [PW-1:0]    hi_reg, hi_next;
    logic             valid_reg [N];
    logic             valid_next [N];
    logic [CW-1:0]    live_reg, live_next;
    logic [CW-1:0]    removed_reg, removed_next;
    logic             have_free_reg, have_free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    isce_pkg::rsp_t   res_reg, res_next;

    logic accept;
    logic hit;
    logic slot_free;
    logic last_chk;
    logic entry_vld;

    assign accept    = req_valid && !req_stall;
    assign entry_vld = ent_vld_reg;
    assign hit       = chk_vld_reg && entry_vld
                       && !(ram_rdata.last < lo_reg) && !(ram_rdata.first > hi_reg);
    assign slot_free = chk_vld_reg && (!entry_vld || hit);
    assign last_chk  = chk_vld_reg && (chk_idx_reg == IW'(N - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.opcode == isce_pkg::OP_QUERY) ? isce_pkg::ST_RESP
                                                                    : isce_pkg::ST_SCAN;
                end
            end
            isce_pkg::ST_SCAN:
            begin
                if (last_chk)
                begin
                    state_next = isce_pkg::ST_FINISH;
                end
            end
            isce_pkg::ST_FINISH:
            begin
                state_next = isce_pkg::ST_RESP;
            end
            isce_pkg::ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = isce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isce_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = 1'b1;
        res_valid = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        case (state_reg)
            isce_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            isce_pkg::ST_SCAN:
            begin
                ram_re = (cnt_reg < (IW + 1)'(N));
            end
            isce_pkg::ST_FINISH:
            begin
                ram_we = have_free_reg;
            end
            isce_pkg::ST_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign ram_raddr       = cnt_reg[IW-1:0];
    assign ram_waddr       = free_idx_reg;
    assign ram_wdata.first = lo_reg;
    assign ram_wdata.last  = hi_reg;
    assign res             = res_reg;

    // datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        chk_vld_next   = ram_re;
        chk_idx_next   = cnt_reg[IW-1:0];
        ent_vld_next   = valid_reg[cnt_reg[IW-1:0]];
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        live_next      = live_reg;
        removed_next   = removed_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        for (int i = 0; i < N; i++)
        begin
            valid_next[i] = valid_reg[i];
        end

        if (accept)
        begin
            cnt_next       = '0;
            lo_next        = req.range_start;
            hi_next        = req.range_end;
            removed_next   = '0;
            have_free_next = 1'b0;
            res_next.count      = isce_pkg::sat_count(live_reg);
            res_next.table_full = 1'b0;
        end

        if (ram_re)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (hit)
        begin
            valid_next[chk_idx_reg] = 1'b0;
            removed_next            = removed_reg + 1'b1;
            if (live_reg != '0)
            begin
                live_next = live_reg - 1'b1;
            end
        end

        if (slot_free && !have_free_reg)
        begin
            have_free_next = 1'b1;
            free_idx_next  = chk_idx_reg;
        end

        if (state_reg == isce_pkg::ST_FINISH)
        begin
            if (have_free_reg)
            begin
                valid_next[free_idx_reg] = 1'b1;
                live_next                = live_reg + 1'b1;
                res_next.count           = isce_pkg::sat_count(removed_reg);
                res_next.table_full      = 1'b0;
            end
            else
            begin
                res_next.count      = '0;
                res_next.table_full = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isce_pkg::ST_IDLE;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            live_reg      <= '0;
            have_free_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            live_reg      <= live_next;
            have_free_reg <= have_free_next;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        ent_vld_reg  <= ent_vld_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        removed_reg  <= removed_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

endmodule

>>> hw/rtl/interval_set_conflict_evict_core.sv
// Interval set core: one request at a time; an insert evicts every stored
// interval that overlaps the new one and stores it in the lowest free entry,
// a query reports how many intervals are stored. An insert walks the entry
// RAM sequentially, one read per cycle; the RAM is written only after the
// walk ends, so reads and writes never overlap. Results sit in an output
// register, so the next request is taken while one waits. Depends on
// isce_pkg, isce_ram and isce_engine.
module interval_set_conflict_evict_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  isce_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output isce_pkg::rsp_t rsp
);

    logic                        res_valid;
    logic                        res_ready;
    isce_pkg::rsp_t              res;
    logic                        ram_re;
    logic                        ram_we;
    logic [isce_pkg::IDX_W-1:0]  ram_raddr;
    logic [isce_pkg::IDX_W-1:0]  ram_waddr;
    isce_pkg::entry_t            ram_rdata;
    isce_pkg::entry_t            ram_wdata;
    logic [isce_pkg::ENTRY_W-1:0] ram_rdata_raw;

    logic           rsp_valid_reg;
    isce_pkg::rsp_t rsp_reg;

    isce_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    isce_ram #(
        .DEPTH  (isce_pkg::TABLE_ENTRIES),
        .DATA_W (isce_pkg::ENTRY_W),
        .ADDR_W (isce_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = isce_pkg::entry_t'(ram_rdata_raw);

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/isce_checker.sv
// Port-level checks for the interval set core, bound to the top level.
// Depends on isce_pkg and interval_set_conflict_evict_core.
module isce_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input isce_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input isce_pkg::rsp_t rsp
);

    // a held result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("held result changed");

    // a refused insert reports no evictions
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> rsp.count == '0)
        else $error("refused insert with nonzero count");

    // one request at a time: busy right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

    // counts never exceed the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.count) <= isce_pkg::TABLE_ENTRIES)
        else $error("count above table size");

endmodule

bind interval_set_conflict_evict_core isce_checker u_isce_checker (.*);
